### rtl/core/integer_to_ascii_formatter_macros.svh
// assertion macros for the integer to ascii formatter, sampled on clk and held off in reset
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define I2A_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("i2a check failed");
// antecedent implies consequent in the same cycle
`define I2A_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2a check failed");
// antecedent implies consequent in the next cycle
`define I2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2a check failed");
`else
`define I2A_ASSERT_HOLDS(label, cond)
`define I2A_ASSERT_IMPL(label, ante, cons)
`define I2A_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/i2a_pkg.sv
// shared widths, mode codes and character constants of the integer to ascii formatter
`default_nettype none

package i2a_pkg;

  // payload widths
  localparam int VALUE_W        = 64;
  localparam int MODE_W         = 2;
  localparam int BYTES_W        = 4;
  localparam int CHAR_W         = 7;

  // default converted width and the widest binary output
  localparam int VALUE_BITS_DEF = 64;
  localparam int BIN_MAX_BITS   = 64;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 4'd8;

  // format codes
  localparam logic [MODE_W-1:0] MODE_HEX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIN = 2'd2;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 7'd55;
  localparam logic [CHAR_W-1:0] CH_X         = 7'd120;

  // one digit (0 to 15) to its upper-case ascii code
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d >= 4'd10) begin
      return dx + CH_ALPHA_OFS;
    end
    return dx + CH_ZERO;
  endfunction

endpackage

`default_nettype wire

### rtl/core/i2a_in_if.sv
// input channel of the formatter: valid, ready and the number to convert
`default_nettype none

interface i2a_in_if;
  logic                         valid;
  logic                         ready;
  logic [i2a_pkg::MODE_W-1:0]   mode;
  logic [i2a_pkg::VALUE_W-1:0]  value;
  logic                         hex_prefix;
  logic [i2a_pkg::BYTES_W-1:0]  byte_count;

  modport source (
    output valid, mode, value, hex_prefix, byte_count,
    input  ready
  );

  modport sink (
    input  valid, mode, value, hex_prefix, byte_count,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/i2a_out_if.sv
// result channel of the formatter: valid, ready and one character
`default_nettype none

interface i2a_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2a_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (
    output valid, character, last,
    input  ready
  );

  modport sink (
    input  valid, character, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/i2a_bcd_step.sv
// one double-dabble step: add-3 correction on every bcd digit, then shift one bit in
`default_nettype none

module i2a_bcd_step #(
  parameter int DIGITS = 20
) (
  input  logic [DIGITS*4-1:0] bcd_i,
  input  logic                bit_i,
  output logic [DIGITS*4-1:0] bcd_o
);

  logic [DIGITS*4-1:0] adj;

  // digits are corrected independently of each other
  for (genvar g = 0; g < DIGITS; g++) begin : g_digit
    always_comb begin
      if (bcd_i[g*4 +: 4] >= 4'd5) begin
        adj[g*4 +: 4] = bcd_i[g*4 +: 4] + 4'd3;
      end else begin
        adj[g*4 +: 4] = bcd_i[g*4 +: 4];
      end
    end
  end

  // shift the corrected digits left, new bit enters at the bottom
  assign bcd_o = {adj[DIGITS*4-2:0], bit_i};

endmodule

`default_nettype wire

### rtl/core/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter: digit register, dabble sequencer, emitter
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    mode, value, hex_prefix, byte_count
//  out_ch   out  valid/ready    character, last
//
// one number at a time; in_ch.ready is high only while the block is idle.
// hex: leading zero digits are skipped, then the optional 0x prefix and the digits are sent.
// decimal: serial double dabble over VALUE_BITS bits, then leading zero digits are
//   skipped and the remaining digits are sent.
// binary: byte_count*8 bits, one character each; an unused mode is taken with no items.
// reset is synchronous, active low; an out_ch stall holds the current character.
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  i2a_in_if.sink        in_ch,
  i2a_out_if.source     out_ch
);

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIG_N      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_W      = DIG_N * 4;
  localparam int BIN_W      = i2a_pkg::BIN_MAX_BITS;
  localparam int CNT_MAX    = (BIN_W > DIG_N) ? BIN_W : DIG_N;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DABBLE = 7'b0000010,
    ST_SKIP   = 7'b0000100,
    ST_PFX0   = 7'b0001000,
    ST_PFX1   = 7'b0010000,
    ST_DIGIT  = 7'b0100000,
    ST_BIN    = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic [BIN_W-1:0]    src_r, src_nxt;
  logic                pfx_r, pfx_nxt;

  logic [VALUE_BITS-1:0]       in_val;
  logic [i2a_pkg::BYTES_W-1:0] bin_bytes;
  logic [CNT_W-1:0]            bin_bits;
  logic [CNT_W-1:0]            bin_sh;
  logic [DIG_W-1:0]            dabble_out;
  logic [3:0]                  top_digit;
  logic                        accept;

  assign in_val    = in_ch.value[VALUE_BITS-1:0];
  assign top_digit = dig_r[DIG_W-1 -: 4];
  assign accept    = in_ch.valid && in_ch.ready;

  // binary width in bytes, clamped to one through eight
  always_comb begin
    if (in_ch.byte_count == '0) begin
      bin_bytes = 4'd1;
    end else if (in_ch.byte_count > i2a_pkg::BYTES_MAX) begin
      bin_bytes = i2a_pkg::BYTES_MAX;
    end else begin
      bin_bytes = in_ch.byte_count;
    end
  end

  assign bin_bits = CNT_W'({bin_bytes, 3'b000});
  assign bin_sh   = CNT_W'(BIN_W) - bin_bits;

  // serial binary to bcd step
  i2a_bcd_step #(
    .DIGITS (DIG_N)
  ) u_bcd_step (
    .bcd_i (dig_r),
    .bit_i (src_r[BIN_W-1]),
    .bcd_o (dabble_out)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    src_nxt   = src_r;
    pfx_nxt   = pfx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.mode)
            i2a_pkg::MODE_HEX: begin
              dig_nxt   = DIG_W'(in_val) << (DIG_W - HEX_W);
              cnt_nxt   = CNT_W'(HEX_DIGITS);
              pfx_nxt   = in_ch.hex_prefix;
              state_nxt = ST_SKIP;
            end
            i2a_pkg::MODE_DEC: begin
              dig_nxt   = '0;
              src_nxt   = BIN_W'(in_val) << (BIN_W - VALUE_BITS);
              cnt_nxt   = CNT_W'(VALUE_BITS);
              state_nxt = ST_DABBLE;
            end
            i2a_pkg::MODE_BIN: begin
              src_nxt   = BIN_W'(in_val) << bin_sh;
              cnt_nxt   = bin_bits;
              state_nxt = ST_BIN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        dig_nxt = dabble_out;
        src_nxt = src_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(DIG_N);
          pfx_nxt   = 1'b0;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (cnt_r > CNT_W'(1) && top_digit == 4'd0) begin
          dig_nxt = dig_r << 4;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (pfx_r) begin
          state_nxt = ST_PFX0;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_PFX0: begin
        if (out_ch.ready) begin
          state_nxt = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (out_ch.ready) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_ch.ready) begin
          dig_nxt = dig_r << 4;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BIN: begin
        if (out_ch.ready) begin
          src_nxt = src_r << 1;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // counters and shift registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dig_r <= dig_nxt;
    src_r <= src_nxt;
    pfx_r <= pfx_nxt;
  end

  // handshakes and character select
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_PFX0) || (state_r == ST_PFX1) ||
                        (state_r == ST_DIGIT) || (state_r == ST_BIN);
  assign out_ch.last  = ((state_r == ST_DIGIT) || (state_r == ST_BIN)) &&
                        (cnt_r == CNT_W'(1));

  always_comb begin
    case (state_r)
      ST_PFX0:  out_ch.character = i2a_pkg::CH_ZERO;
      ST_PFX1:  out_ch.character = i2a_pkg::CH_X;
      ST_DIGIT: out_ch.character = i2a_pkg::digit_char(top_digit);
      ST_BIN:   out_ch.character = i2a_pkg::CH_ZERO +
                                   i2a_pkg::CHAR_W'(src_r[BIN_W-1]);
      default:  out_ch.character = '0;
    endcase
  end

  // checks
  `I2A_ASSERT_IMPL(a_idle_no_out, in_ch.ready, !out_ch.valid)
  `I2A_ASSERT_IMPL(a_emit_cnt, (state_r == ST_DIGIT) || (state_r == ST_BIN), cnt_r != '0)
  `I2A_ASSERT_IMPL(a_skip_cnt, state_r == ST_SKIP, (cnt_r != '0) && (cnt_r <= CNT_W'(DIG_N)))
  `I2A_ASSERT_NEXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.last, state_r == ST_IDLE)
  `I2A_ASSERT_NEXT(a_unused_mode, accept && (in_ch.mode > i2a_pkg::MODE_BIN), state_r == ST_IDLE)

endmodule

`default_nettype wire

### tb/sv/integer_to_ascii_formatter_tb.sv
// self-checking testbench of the integer to ascii formatter: stimulus, character predictor, scoreboard
`default_nettype none

module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  localparam int NUM_RANDOM = 357;
  localparam int DRAIN_CYCLES = 150;

  // format code with no meaning, emits nothing
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // one emitted character as seen on the result channel
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_item_t;

  // predicts the character stream of each accepted number and checks the output against it
  class char_scoreboard;
    char_item_t expected_chars[$];
    int         failures;

    function new();
      failures = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // expand one accepted number into the characters it must produce
    function void note_number(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                              logic hex_prefix, logic [BYTES_W-1:0] byte_count);
      char_item_t        chars[$];
      char_item_t        c;
      int                ndig;
      int                nbits;
      logic [3:0]        nib;
      logic [VALUE_W-1:0] rest;
      logic [3:0]        dec_digits[20];
      c.last = 1'b0;
      case (mode)
        MODE_HEX: begin
          // drop leading zero nibbles, keep at least one digit
          ndig = 16;
          while (ndig > 1 && value[(ndig-1)*4 +: 4] == 4'd0) ndig--;
          if (hex_prefix) begin
            c.character = CH_ZERO;
            chars.push_back(c);
            c.character = CH_X;
            chars.push_back(c);
          end
          for (int i = ndig - 1; i >= 0; i--) begin
            nib = value[i*4 +: 4];
            c.character = (nib >= 4'd10) ? CHAR_W'(nib) + CH_ALPHA_OFS : CHAR_W'(nib) + CH_ZERO;
            chars.push_back(c);
          end
        end
        MODE_DEC: begin
          // collect decimal digits least significant first
          ndig = 0;
          rest = value;
          do begin
            dec_digits[ndig] = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            ndig++;
          end while (rest != 0 && ndig < 20);
          for (int i = ndig - 1; i >= 0; i--) begin
            c.character = CHAR_W'(dec_digits[i]) + CH_ZERO;
            chars.push_back(c);
          end
        end
        MODE_BIN: begin
          // zero bytes means one byte, more than eight saturates
          if (byte_count == 4'd0) nbits = 8;
          else if (byte_count > BYTES_MAX) nbits = BIN_MAX_BITS;
          else nbits = int'(byte_count) * 8;
          for (int i = nbits - 1; i >= 0; i--) begin
            c.character = CH_ZERO + CHAR_W'(value[i]);
            chars.push_back(c);
          end
        end
        default: begin
          // unused mode emits nothing
        end
      endcase
      if (chars.size() > 0) chars[chars.size()-1].last = 1'b1;
      foreach (chars[i]) expected_chars.push_back(chars[i]);
    endfunction

    // compare one accepted character with the oldest prediction
    function void check_char(logic [CHAR_W-1:0] character, logic last);
      char_item_t exp_c;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, character, last);
        failures++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (character !== exp_c.character) begin
        $display("%0t: character mismatch, expected %h, actual %h",
                 $time, exp_c.character, character);
        failures++;
      end
      if (last !== exp_c.last) begin
        $display("%0t: last mismatch, expected %b, actual %b", $time, exp_c.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic steady;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();

  integer_to_ascii_formatter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_scoreboard digits_sb;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known values on every input from the start
  initial begin
    rst_n            = 1'b0;
    steady           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_HEX;
    in_ch.value      = '0;
    in_ch.hex_prefix = 1'b0;
    in_ch.byte_count = '0;
    out_ch.ready     = 1'b0;
    digits_sb        = new();
  end

  // receiver stalls about 15 percent of the time unless in a steady stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 15);
    end
  end

  // watch both channels: check characters, note accepted numbers
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        digits_sb.check_char(out_ch.character, out_ch.last);
      end
      if (in_ch.valid && in_ch.ready) begin
        digits_sb.note_number(in_ch.mode, in_ch.value, in_ch.hex_prefix, in_ch.byte_count);
      end
    end
  end

  // offer one number and hold it until the block takes it
  task automatic send_number(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                             input logic hex_prefix, input logic [BYTES_W-1:0] byte_count);
    if (!steady) begin
      while ($urandom_range(99) < 15) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.value      <= value;
    in_ch.hex_prefix <= hex_prefix;
    in_ch.byte_count <= byte_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // number with a spread of magnitudes
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = VALUE_W'($urandom_range(15));
      1: v = VALUE_W'($urandom);
      2: v = {$urandom, $urandom};
      3: v = $urandom_range(1) ? '1 : '0;
      4: v = (VALUE_W'(1) << $urandom_range(63)) - VALUE_W'($urandom_range(1));
      default: v = v >> $urandom_range(63);
    endcase
    return v;
  endfunction

  // random number with a random format
  task automatic send_random();
    logic [MODE_W-1:0]  mode;
    logic [BYTES_W-1:0] byte_count;
    int                 r;
    r = $urandom_range(99);
    if (r < 35) mode = MODE_HEX;
    else if (r < 70) mode = MODE_DEC;
    else if (r < 95) mode = MODE_BIN;
    else mode = MODE_UNUSED;
    if ($urandom_range(99) < 80) byte_count = BYTES_W'($urandom_range(8));
    else byte_count = BYTES_W'($urandom_range(15, 9));
    send_number(mode, pick_value(), 1'($urandom_range(1)), byte_count);
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hex extremes, with and without the prefix
    send_number(MODE_HEX, 64'd0, 1'b0, 4'd0);
    send_number(MODE_HEX, 64'd0, 1'b1, 4'd0);
    send_number(MODE_HEX, '1, 1'b1, 4'd15);
    send_number(MODE_HEX, 64'h1234_5678_9ABC_DEF0, 1'b0, 4'd3);
    send_number(MODE_HEX, 64'hA, 1'b1, 4'd0);
    send_number(MODE_HEX, 64'h8000_0000_0000_0000, 1'b0, 4'd0);
    // decimal extremes and digit rollovers, prefix ignored
    send_number(MODE_DEC, 64'd0, 1'b0, 4'd0);
    send_number(MODE_DEC, '1, 1'b1, 4'd0);
    send_number(MODE_DEC, 64'd9, 1'b0, 4'd0);
    send_number(MODE_DEC, 64'd10, 1'b1, 4'd0);
    send_number(MODE_DEC, 64'd10000000000000000000, 1'b0, 4'd8);
    send_number(MODE_DEC, 64'd9999999999999999999, 1'b0, 4'd0);
    // binary: zero value, zero byte count, saturated byte count, prefix ignored
    send_number(MODE_BIN, 64'd0, 1'b0, 4'd0);
    send_number(MODE_BIN, 64'd0, 1'b0, 4'd8);
    send_number(MODE_BIN, '1, 1'b0, 4'd8);
    send_number(MODE_BIN, '1, 1'b1, 4'd15);
    send_number(MODE_BIN, 64'hA5A5_0F0F_3C3C_9669, 1'b0, 4'd9);
    send_number(MODE_BIN, 64'hA5, 1'b1, 4'd1);
    send_number(MODE_BIN, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 4'd1);
    send_number(MODE_BIN, 64'h0123_4567_89AB_CDEF, 1'b0, 4'd5);
    // unused mode produces nothing
    send_number(MODE_UNUSED, '1, 1'b1, 4'd15);
    send_number(MODE_UNUSED, 64'd0, 1'b0, 4'd0);
    send_number(MODE_HEX, 64'hF, 1'b0, 4'd0);

    // random numbers, with a stretch where neither side idles
    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady <= (n >= 150 && n < 230);
      send_random();
    end
    in_ch.valid <= 1'b0;
    steady      <= 1'b0;

    // drain outstanding characters, then let the last number finish
    while (digits_sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (digits_sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
